// ===== sv/nsf_pkg.sv =====
package nsf_pkg;

   localparam int MAX_TYPE_CHARS    = 6;
   localparam int MAX_PAYLOAD_CHARS = 100;

   localparam int TypeCntW = $clog2(MAX_TYPE_CHARS + 1);
   localparam int PayCntW  = $clog2(MAX_PAYLOAD_CHARS + 1);

   localparam int ByteW    = 8;
   localparam int EventW   = 3;
   localparam int PosW     = 7;
   localparam int TypeLenW = 3;
   localparam int PayLenW  = 7;

   localparam logic [ByteW-1:0] CH_DOLLAR = 8'h24;
   localparam logic [ByteW-1:0] CH_COMMA  = 8'h2C;
   localparam logic [ByteW-1:0] CH_STAR   = 8'h2A;

   typedef enum logic [EventW-1:0] {
      EV_IGNORED      = 3'd0,
      EV_START        = 3'd1,
      EV_TYPE_CHAR    = 3'd2,
      EV_PAYLOAD_CHAR = 3'd3,
      EV_COMPLETE     = 3'd4,
      EV_DROPPED      = 3'd5
   } event_type;

   typedef enum logic [1:0] {
      MODE_HUNT    = 2'd0,
      MODE_TYPE    = 2'd1,
      MODE_PAYLOAD = 2'd2
   } mode_type;

   typedef struct packed {
      mode_type            mode;
      logic [TypeCntW-1:0] type_count;
      logic [PayCntW-1:0]  payload_count;
   } parse_state_type;

   typedef struct packed {
      event_type           event_kind;
      logic [PosW-1:0]     store_position;
      logic [ByteW-1:0]    store_byte;
      logic [TypeLenW-1:0] type_length;
      logic [PayLenW-1:0]  payload_length;
   } result_type;

endpackage

// ===== sv/nsf_step.sv =====
module nsf_step (
   input  nsf_pkg::parse_state_type cur_state,
   input  logic [7:0]               in_byte,
   output nsf_pkg::parse_state_type next_state,
   output nsf_pkg::result_type      result
);
   import nsf_pkg::*;

   logic type_full;
   logic pay_full;

   assign type_full = (cur_state.type_count >= TypeCntW'(MAX_TYPE_CHARS));
   assign pay_full  = (cur_state.payload_count >= PayCntW'(MAX_PAYLOAD_CHARS));

   always_comb begin
      next_state = cur_state;
      result     = '0;
      result.event_kind = EV_IGNORED;
      unique case (cur_state.mode)
         MODE_TYPE: begin
            priority if (in_byte == CH_COMMA) begin
               // comma is consumed, even on a full type
               next_state.mode          = MODE_PAYLOAD;
               next_state.payload_count = '0;
            end else if (type_full) begin
               next_state.mode       = MODE_HUNT;
               next_state.type_count = '0;
               result.event_kind     = EV_DROPPED;
            end else if (in_byte == CH_STAR) begin
               next_state.mode    = MODE_HUNT;
               result.event_kind  = EV_COMPLETE;
               result.type_length = TypeLenW'(cur_state.type_count);
            end else begin
               next_state.type_count = cur_state.type_count + 1'b1;
               result.event_kind     = EV_TYPE_CHAR;
               result.store_position = PosW'(cur_state.type_count);
               result.store_byte     = in_byte;
            end
         end
         MODE_PAYLOAD: begin
            priority if (in_byte == CH_STAR) begin
               next_state.mode       = MODE_HUNT;
               result.event_kind     = EV_COMPLETE;
               result.type_length    = TypeLenW'(cur_state.type_count);
               result.payload_length = PayLenW'(cur_state.payload_count);
            end else if (pay_full) begin
               next_state.mode          = MODE_HUNT;
               next_state.payload_count = '0;
               result.event_kind        = EV_DROPPED;
            end else begin
               next_state.payload_count = cur_state.payload_count + 1'b1;
               result.event_kind        = EV_PAYLOAD_CHAR;
               result.store_position    = PosW'(cur_state.payload_count);
               result.store_byte        = in_byte;
            end
         end
         default: begin
            // hunt, and the unused mode code
            if (in_byte == CH_DOLLAR) begin
               next_state.mode       = MODE_TYPE;
               next_state.type_count = '0;
               result.event_kind     = EV_START;
            end else begin
               next_state.mode = MODE_HUNT;
            end
         end
      endcase
   end

endmodule

// ===== sv/nmea_sentence_framer.sv =====
// A request passes through the input register, then the result register.
// Throughput: one request per cycle while rsp_ready is high; the framing state updates as
// a request moves from the input register into the result register.
// Reset (synchronous, active high): both stages empty, hunting for '$',
// type and payload counters cleared.
module nmea_sentence_framer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [nsf_pkg::ByteW-1:0]     req_in_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [nsf_pkg::EventW-1:0]    rsp_event_kind,
   output logic [nsf_pkg::PosW-1:0]      rsp_store_position,
   output logic [nsf_pkg::ByteW-1:0]     rsp_store_byte,
   output logic [nsf_pkg::TypeLenW-1:0]  rsp_type_length,
   output logic [nsf_pkg::PayLenW-1:0]   rsp_payload_length
);
   import nsf_pkg::*;

   logic             in_valid_ff;
   logic             in_valid_in;
   logic [ByteW-1:0] in_byte_ff;
   logic             out_valid_ff;
   logic             out_valid_in;
   result_type       out_ff;
   parse_state_type  state_ff;
   parse_state_type  state_next;
   result_type       step_result;
   logic             advance;

   nsf_step u_step (
      .cur_state  (state_ff),
      .in_byte    (in_byte_ff),
      .next_state (state_next),
      .result     (step_result)
   );

   // advance the input stage when the result register is free or being drained
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || advance;
   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '{mode: MODE_HUNT, type_count: '0, payload_count: '0};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
      end
      if (advance) begin
         out_ff <= step_result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_event_kind     = out_ff.event_kind;
   assign rsp_store_position = out_ff.store_position;
   assign rsp_store_byte     = out_ff.store_byte;
   assign rsp_type_length    = out_ff.type_length;
   assign rsp_payload_length = out_ff.payload_length;

   a_type_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.type_count <= TypeCntW'(MAX_TYPE_CHARS))
      else $error("type counter beyond limit");

   a_pay_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.payload_count <= PayCntW'(MAX_PAYLOAD_CHARS))
      else $error("payload counter beyond limit");

   a_start: assert property (@(posedge clock) disable iff (reset)
      advance && state_ff.mode == MODE_HUNT && in_byte_ff == CH_DOLLAR
      |=> state_ff.mode == MODE_TYPE && state_ff.type_count == '0
          && out_ff.event_kind == EV_START)
      else $error("start character did not enter type mode");

   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready |=> out_valid_ff && !$past(advance))
      else $error("result overwritten while stalled");

endmodule
